@@ rtl/core/rnf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter package
// Field widths, table default size and the packed table entry layout.
// ----------------------------------------------------------------------------
package rnf_pkg;

  localparam int SRC_W            = 8;
  localparam int NONCE_W          = 32;
  localparam int TIME_W           = 32;
  localparam int TABLE_ENTRIES_DEF = 16;

  // One table entry as stored in the entry RAM (valid bit lives in flops).
  typedef struct packed {
    logic [SRC_W-1:0]   source;
    logic [NONCE_W-1:0] nonce_mark;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/core/rnf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter message channel
// Valid/ready channel carrying one control message word.
// ----------------------------------------------------------------------------
interface rnf_in_if;
  import rnf_pkg::*;

  logic               valid;
  logic               ready;
  logic [SRC_W-1:0]   source_id;
  logic [NONCE_W-1:0] msg_nonce;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, output source_id, output msg_nonce, output now_ms,
                  input ready);
  modport sink   (input valid, input source_id, input msg_nonce, input now_ms,
                  output ready);
endinterface

@@ rtl/core/rnf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter verdict channel
// Valid/ready channel carrying one verdict word per message.
// ----------------------------------------------------------------------------
interface rnf_out_if;
  import rnf_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [NONCE_W-1:0] highest_nonce;

  modport source (output valid, output accepted, output highest_nonce, input ready);
  modport sink   (input valid, input accepted, input highest_nonce, output ready);
endinterface

@@ rtl/core/rnf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/replay_nonce_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter
// Per-source monotonic nonce table: rejects a message whose nonce does not
// exceed the last one recorded for its source, records fresh ones.
// ----------------------------------------------------------------------------
//
//  channel  | role | word contents
//  ---------+------+----------------------------------------------
//  msg      | sink | source_id[7:0], msg_nonce[31:0], now_ms[31:0]
//  verdict  | src  | accepted, highest_nonce[31:0]
//
//  Each message walks the table in index order, one entry at a time through
//  the single entry RAM read port, until an empty entry, its own source or
//  the last entry, then takes an update step before the walker is idle.
//  msg.ready is high only while the walker is idle; a verdict still pending
//  when a walk ends holds the update state until verdict.ready.
//  Reset (rst, synchronous) clears the valid bits and the highest nonce.
//
module replay_nonce_filter_top #(
  parameter int TABLE_ENTRIES = rnf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  rnf_in_if.sink    msg,
  rnf_out_if.source verdict
);
  import rnf_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]               state;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         slot;
  logic [IDX_W-1:0]         victim;
  logic [TIME_W-1:0]        victim_stamp;
  logic                     known;
  logic [NONCE_W-1:0]       stored_nonce;
  logic [SRC_W-1:0]         cur_src;
  logic [NONCE_W-1:0]       cur_nonce;
  logic [TIME_W-1:0]        cur_now;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [NONCE_W-1:0]       highest;
  logic [NONCE_W-1:0]       highest_next;

  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  entry_t             wr_entry;
  entry_t             rd_entry;

  logic msg_take;
  logic ent_valid;
  logic src_hit;
  logic take_victim;
  logic is_last;
  logic fresh;
  logic advance;

  // Entry storage: source, last nonce and stamp; valid bits stay in flops.
  rnf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign msg.ready = (state == ST_IDLE);
  assign msg_take  = msg.valid && msg.ready;

  // Prefetch entry 0 on accept, then the entry after the one being checked.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      ST_IDLE: begin
        ram_re    = msg_take;
        ram_raddr = '0;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx + IDX_W'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  // Walk compare: empty entry, source hit, or oldest-stamp candidate.
  assign rd_entry    = entry_t'(ram_rdata);
  assign ent_valid   = valid_bits[idx];
  assign src_hit     = (rd_entry.source == cur_src);
  assign take_victim = (idx == '0) || (rd_entry.stamp < victim_stamp);
  assign is_last     = (idx == LAST_IDX);

  // Update: a known source must move its nonce strictly forward.
  assign fresh        = !known || (cur_nonce > stored_nonce);
  assign highest_next = (fresh && (cur_nonce > highest)) ? cur_nonce : highest;
  assign advance      = (state == ST_UPDATE) && (!verdict.valid || verdict.ready);
  assign ram_we       = advance && fresh;

  assign wr_entry.source     = cur_src;
  assign wr_entry.nonce_mark = cur_nonce;
  assign wr_entry.stamp      = cur_now;

  // Sequencer and table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      highest    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (msg_take) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!ent_valid || src_hit || is_last) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (advance) begin
            state   <= ST_IDLE;
            highest <= highest_next;
            if (fresh) begin
              valid_bits[slot] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk datapath: latch message, step index, track victim and pick slot.
  always_ff @(posedge clk) begin
    if (msg_take) begin
      cur_src   <= msg.source_id;
      cur_nonce <= msg.msg_nonce;
      cur_now   <= msg.now_ms;
      idx       <= '0;
    end
    if (state == ST_SCAN) begin
      if (!ent_valid) begin
        slot  <= idx;
        known <= 1'b0;
      end else if (src_hit) begin
        slot         <= idx;
        known        <= 1'b1;
        stored_nonce <= rd_entry.nonce_mark;
      end else begin
        if (take_victim) begin
          victim       <= idx;
          victim_stamp <= rd_entry.stamp;
        end
        if (is_last) begin
          slot  <= take_victim ? idx : victim;
          known <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // Verdict register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (advance) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict.accepted      <= fresh;
      verdict.highest_nonce <= highest_next;
    end
  end

  // Highest accepted nonce never moves backward.
  a_highest_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> highest >= $past(highest))
    else $error("highest accepted nonce decreased");

  // Entries are never invalidated outside reset.
  a_valid_grow: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (valid_bits & $past(valid_bits)) == $past(valid_bits))
    else $error("table entry lost its valid bit");

  // A recorded message leaves its slot valid.
  a_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (advance && fresh) |=> valid_bits[$past(slot)])
    else $error("recorded slot not marked valid");

  // The walk never runs past the last entry.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= LAST_IDX))
    else $error("walk index beyond table");

  // A verdict accepted flag implies the reported high mark covers nothing
  // lower than the message just recorded.
  a_verdict_cover: assert property (@(posedge clk) disable iff (rst)
    (advance && fresh) |=> verdict.highest_nonce >= $past(cur_nonce))
    else $error("verdict high mark below recorded nonce");

endmodule

@@ tb/sv/replay_verdict_predictor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay verdict predictor
// Watches the message and verdict channels, keeps its own per-source nonce
// table, and compares every verdict word with the predicted one.
// ----------------------------------------------------------------------------
module replay_verdict_predictor #(
  parameter int ENTRIES = rnf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  rnf_in_if    msg,
  rnf_out_if   verdict,
  output int   mismatches,
  output int   outstanding,
  output int   fresh_words,
  output int   replay_words,
  output int   evict_words
);
  import rnf_pkg::*;

  typedef struct {
    logic               accepted;
    logic [NONCE_W-1:0] highest;
  } verdict_t;

  logic               tbl_valid  [ENTRIES];
  logic [SRC_W-1:0]   tbl_source [ENTRIES];
  logic [NONCE_W-1:0] tbl_nonce  [ENTRIES];
  logic [TIME_W-1:0]  tbl_stamp  [ENTRIES];
  logic [NONCE_W-1:0] top_nonce;
  verdict_t           verdict_q[$];

  initial begin
    mismatches   = 0;
    fresh_words  = 0;
    replay_words = 0;
    evict_words  = 0;
    outstanding  = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    logic     found;
    logic     hit;
    logic     ok;
    int       slot;
    int       oldest;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_valid[i]  = 1'b0;
        tbl_source[i] = '0;
        tbl_nonce[i]  = '0;
        tbl_stamp[i]  = '0;
      end
      top_nonce = '0;
      verdict_q.delete();
    end else begin
      if (verdict.valid && verdict.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict word with no message outstanding");
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, verdict.accepted);
            mismatches++;
          end
          if (verdict.highest_nonce !== want.highest) begin
            $error("highest_nonce: expected 0x%08h, got 0x%08h",
                   want.highest, verdict.highest_nonce);
            mismatches++;
          end
        end
      end
      if (msg.valid && msg.ready) begin
        // Walk in index order: stop at the owner or the first empty entry,
        // otherwise remember the oldest stamp (lowest index on a tie).
        found  = 1'b0;
        hit    = 1'b0;
        slot   = 0;
        oldest = -1;
        for (int i = 0; i < ENTRIES && !found; i++) begin
          if (!tbl_valid[i]) begin
            slot  = i;
            found = 1'b1;
          end else if (tbl_source[i] == msg.source_id) begin
            slot  = i;
            found = 1'b1;
            hit   = 1'b1;
          end else if (oldest < 0 || tbl_stamp[i] < tbl_stamp[oldest]) begin
            oldest = i;
          end
        end
        if (!found) slot = oldest;
        ok = !(hit && msg.msg_nonce <= tbl_nonce[slot]);
        if (ok) begin
          if (!found) evict_words++;
          tbl_valid[slot]  = 1'b1;
          tbl_source[slot] = msg.source_id;
          tbl_nonce[slot]  = msg.msg_nonce;
          tbl_stamp[slot]  = msg.now_ms;
          if (msg.msg_nonce > top_nonce) top_nonce = msg.msg_nonce;
          fresh_words++;
        end else begin
          replay_words++;
        end
        want.accepted = ok;
        want.highest  = top_nonce;
        verdict_q.push_back(want);
      end
    end
    outstanding <= verdict_q.size();
  end

endmodule

@@ tb/sv/replay_nonce_filter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay nonce filter testbench
// Drives control messages into the filter, stalls the verdict side at
// random, and lets the verdict predictor check every verdict word.
// ----------------------------------------------------------------------------
module replay_nonce_filter_top_tb;
  import rnf_pkg::*;

  localparam int ENTRIES      = TABLE_ENTRIES_DEF;
  localparam int RANDOM_WORDS = 750;
  localparam int CALM_WORDS   = 80;    // final stretch with no idling at all
  localparam int HOLD_CYCLES  = 300;   // one long verdict hold-off
  localparam int HOLD_AFTER   = 60;    // verdict words taken before the hold-off
  localparam int DRAIN_LIMIT  = 20000;

  logic clk;
  logic rst;

  rnf_in_if  msg_ch ();
  rnf_out_if verdict_ch ();

  int mismatches;
  int outstanding;
  int fresh_words;
  int replay_words;
  int evict_words;

  // Idling knobs: calm, shared by both sides, turns idling off at the end; gap_pct is the message side's.
  logic calm;
  int   gap_pct;

  replay_nonce_filter_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_ch),
    .verdict (verdict_ch)
  );

  replay_verdict_predictor #(
    .ENTRIES(ENTRIES)
  ) u_predict (
    .clk          (clk),
    .rst          (rst),
    .msg          (msg_ch),
    .verdict      (verdict_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .fresh_words  (fresh_words),
    .replay_words (replay_words),
    .evict_words  (evict_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up long after the slowest correct run would have finished.
  initial begin
    #5000000;
    $display("FAIL replay_nonce_filter_top");
    $finish;
  end

  // Offer one message word and hold it until the filter takes it. An idle
  // burst, when one is drawn, drops valid first; otherwise valid stays high
  // straight into the next word.
  task automatic offer_message(input logic [SRC_W-1:0]   src,
                               input logic [NONCE_W-1:0] nonce,
                               input logic [TIME_W-1:0]  now);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.source_id <= src;
    msg_ch.msg_nonce <= nonce;
    msg_ch.now_ms    <= now;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
  endtask

  // Verdict side: mostly ready, random stall bursts, and a single long
  // hold-off early in the run so the output register and the walker both
  // fill and msg.ready drops while messages keep coming.
  initial begin
    int taken;
    int stall_pct;
    int beat;
    logic squeezed;
    taken     = 0;
    stall_pct = 0;
    beat      = 0;
    squeezed  = 1'b0;
    verdict_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (verdict_ch.valid && verdict_ch.ready) taken++;
      // Re-draw the stall rate now and then, zero included, so some stretches
      // run without any back-pressure.
      if (beat % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      beat++;
      if (!squeezed && taken >= HOLD_AFTER) begin
        squeezed = 1'b1;
        verdict_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        verdict_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        verdict_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus, drain and verdict.
  initial begin
    logic [NONCE_W-1:0] tip  [256];
    logic               seen [256];
    logic [SRC_W-1:0]   src;
    logic [NONCE_W-1:0] nonce;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  clock_ms;
    int                 pool_base;
    int                 pool_size;
    int                 roll;
    int                 spins;
    for (int i = 0; i < 256; i++) begin
      tip[i]  = '0;
      seen[i] = 1'b0;
    end
    clock_ms  = '0;
    pool_base = 0;
    pool_size = 16;
    calm      = 1'b0;
    gap_pct   = 20;

    rst                  <= 1'b1;
    msg_ch.valid         <= 1'b0;
    msg_ch.source_id     <= '0;
    msg_ch.msg_nonce     <= '0;
    msg_ch.now_ms        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Time zero is an ordinary stamp: the entry must still count as valid.
    offer_message(8'h00, 32'd5, 32'd0);
    offer_message(8'h00, 32'd5, 32'd0);     // equal nonce: replay
    offer_message(8'h00, 32'd4, 32'd0);     // lower nonce: replay
    offer_message(8'h00, 32'd6, 32'd0);     // fresh again
    offer_message(8'hFF, 32'd0, 32'd0);     // new source at nonce zero, highest holds
    // Fill the rest of the table with newer stamps.
    for (int s = 1; s <= ENTRIES - 2; s++) begin
      offer_message(SRC_W'(s), NONCE_W'(100 + s), TIME_W'(100 + s));
    end
    // Full table, two entries tied at stamp zero: evict the lower index.
    offer_message(8'h80, '1, '1);
    // Source zero was forgotten, so any nonce is fresh; evicts the 0xFF entry.
    offer_message(8'h00, 32'd1, 32'd7);
    offer_message(8'h80, '1, 32'd8);        // replay at the top nonce
    // No wrap correction: the all-ones stamp is the newest, never the victim.
    offer_message(8'h81, 32'd1, 32'd0);
    offer_message(8'h55, 32'hAAAA_5555, 32'h5555_AAAA);

    // Random part: mostly climbing nonces from a working set of sources that
    // is sometimes larger than the table, some replays, and some noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n % 100 == 0) begin
        pool_base = $urandom_range(0, 255);
        case ($urandom_range(0, 4))
          0:       pool_size = 4;
          1:       pool_size = ENTRIES - 1;
          2:       pool_size = ENTRIES;
          3:       pool_size = ENTRIES + 1;
          default: pool_size = 2 * ENTRIES;
        endcase
      end
      calm = (n >= RANDOM_WORDS - CALM_WORDS);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        src   = SRC_W'($urandom);
        nonce = $urandom;
        now   = $urandom;
      end else begin
        src = SRC_W'(pool_base + $urandom_range(0, pool_size - 1));
        if (!seen[src]) begin
          seen[src] = 1'b1;
          tip[src]  = $urandom >> $urandom_range(0, 31);
        end
        if (roll < 24) begin
          nonce = tip[src] - $urandom_range(0, 3);
        end else begin
          tip[src] = tip[src] + $urandom_range(1, 5000);
          nonce    = tip[src];
        end
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 40);
        now = clock_ms;
      end
      offer_message(src, nonce, now);
    end
    msg_ch.valid <= 1'b0;

    // Drain: let the last push reach the predictor, then wait it out.
    @(posedge clk);
    spins = 0;
    while (outstanding != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (2 * ENTRIES + 8) @(posedge clk);

    $display("Ran %0d message words: %0d fresh, %0d replays, %0d table evictions.",
             fresh_words + replay_words, fresh_words, replay_words, evict_words);
    $display("Verdict side held off for %0d cycles once, plus random idle bursts.",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS replay_nonce_filter_top");
    end else begin
      $display("FAIL replay_nonce_filter_top");
    end
    $finish;
  end

endmodule
